### hw/rtl/tlnef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text line number and escape filter package
// Shared constants, types and helper functions of the text formatting filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

	// Columns of the printed line number and the digits actually stored.
	localparam int NUMBER_DIGITS = 6;
	localparam int BCD_DIGITS    = 6;
	localparam int LIMIT_DIGITS  = (NUMBER_DIGITS < BCD_DIGITS) ? NUMBER_DIGITS : BCD_DIGITS;
	localparam int BCD_W         = 4 * BCD_DIGITS;
	localparam int COL_W         = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

	// Depth of the queue between the classifier and the expander.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_CONTROL    = 3'd5;

	// Character codes.
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DOLLAR    = 8'h24;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_UPPER_I   = 8'h49;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CARET_OFFSET = 8'd64;
	localparam logic [7:0] CONTROL_MAX  = 8'd31;

	// Option bits as held by the configuration registers.
	typedef struct packed {
		logic number_all_lines;
		logic number_nonblank_lines;
		logic squeeze_blank_lines;
		logic show_line_ends;
		logic show_tab_chars;
		logic show_control_chars;
	} cfg_t;

	// One classified input byte, ready for expansion.
	typedef struct packed {
		logic             num_en;
		logic [BCD_W-1:0] bcd;
		logic             dollar_en;
		logic             caret_en;
		logic [7:0]       ch;
	} entry_t;

	// Saturating BCD increment over the low LIMIT_DIGITS digits.
	function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] value);
		logic [BCD_W-1:0] res;
		logic             all_nine;
		logic             carry;
		logic [3:0]       d;
		res      = value;
		all_nine = 1'b1;
		carry    = 1'b1;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (i < LIMIT_DIGITS && value[4*i +: 4] != 4'd9) begin
				all_nine = 1'b0;
			end
		end
		if (!all_nine) begin
			for (int i = 0; i < BCD_DIGITS; i++) begin
				d = value[4*i +: 4];
				if (carry) begin
					if (d >= 4'd9) begin
						res[4*i +: 4] = 4'd0;
					end else begin
						res[4*i +: 4] = d + 4'd1;
						carry         = 1'b0;
					end
				end
			end
		end
		return res;
	endfunction

	// Digit shown in a column; columns beyond the stored digits read as zero.
	function automatic logic [3:0] digit_at(input logic [BCD_W-1:0] value,
			input logic [COL_W-1:0] col);
		logic [3:0] d;
		d = 4'd0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (i < NUMBER_DIGITS && col == COL_W'(i)) begin
				d = value[4*i +: 4];
			end
		end
		return d;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/tlnef_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Raw byte channel
// Valid/ready channel that carries one raw text byte per transfer.
// ----------------------------------------------------------------------------
interface tlnef_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

### hw/rtl/tlnef_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Formatted byte channel
// Valid/ready channel that carries one formatted byte and its run end mark.
// ----------------------------------------------------------------------------
interface tlnef_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;

	modport source (output valid, output out_byte, output run_end, input ready);
	modport sink (input valid, input out_byte, input run_end, output ready);
endinterface
`default_nettype wire

### hw/rtl/tlnef_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and one bit of data.
// ----------------------------------------------------------------------------
interface tlnef_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [tlnef_pkg::CFG_IDX_W-1:0] index;
	logic                               wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### hw/rtl/tlnef_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte classifier
// Accepts raw bytes, keeps the line state and counter, and queues one
// classified entry per byte that is not squeezed away.
// ----------------------------------------------------------------------------
module tlnef_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tlnef_pkg::cfg_t   cfg,
	tlnef_in_if.sink               raw,
	input  wire logic              q_full,
	output logic                   push,
	output tlnef_pkg::entry_t      entry
);

	logic                        after_newline_q;
	logic                        blank_emitted_q;
	logic [tlnef_pkg::BCD_W-1:0] count_q;
	logic [tlnef_pkg::BCD_W-1:0] count_inc;
	logic                        accept;
	logic                        is_nl;
	logic                        is_tab;
	logic                        drop;
	logic                        number;

	// The queue alone holds back the input.
	assign raw.ready = !q_full;
	assign accept    = raw.valid && raw.ready;

	// Classify the byte against the current line state.
	assign is_nl     = (raw.data_byte == tlnef_pkg::CH_NEWLINE);
	assign is_tab    = (raw.data_byte == tlnef_pkg::CH_TAB);
	assign drop      = cfg.squeeze_blank_lines && after_newline_q && is_nl && blank_emitted_q;
	assign number    = after_newline_q &&
		((cfg.number_all_lines && !cfg.number_nonblank_lines) ||
		(cfg.number_nonblank_lines && !is_nl));
	assign count_inc = tlnef_pkg::bcd_inc(count_q);
	assign push      = accept && !drop;

	// Build the queue entry.
	always_comb begin
		entry.num_en    = number;
		entry.bcd       = count_inc;
		entry.dollar_en = cfg.show_line_ends && is_nl;
		entry.caret_en  = 1'b0;
		entry.ch        = raw.data_byte;
		if (cfg.show_tab_chars && is_tab) begin
			entry.caret_en = 1'b1;
			entry.ch       = tlnef_pkg::CH_UPPER_I;
		end else if (cfg.show_control_chars && raw.data_byte <= tlnef_pkg::CONTROL_MAX &&
				!is_nl && !is_tab) begin
			entry.caret_en = 1'b1;
			entry.ch       = raw.data_byte + tlnef_pkg::CARET_OFFSET;
		end
	end

	// Line state advances on every unsqueezed byte, the counter on numbered ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_newline_q <= 1'b1;
			blank_emitted_q <= 1'b0;
			count_q         <= '0;
		end else if (push) begin
			after_newline_q <= is_nl;
			blank_emitted_q <= after_newline_q && is_nl;
			if (number) begin
				count_q <= count_inc;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tlnef_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Entry queue
// Short first-in first-out queue between the classifier and the expander.
// ----------------------------------------------------------------------------
module tlnef_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tlnef_pkg::entry_t  wr_entry,
	input  wire logic               pop,
	output logic                    full,
	output logic                    head_valid,
	output tlnef_pkg::entry_t       head
);

	tlnef_pkg::entry_t               mem_q [tlnef_pkg::QUEUE_DEPTH];
	logic [tlnef_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [tlnef_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [tlnef_pkg::QCNT_W-1:0]    count_q;

	assign full       = (count_q == tlnef_pkg::QCNT_W'(tlnef_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Storage is written in place; no reset needed.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == tlnef_pkg::QPTR_W'(tlnef_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == tlnef_pkg::QPTR_W'(tlnef_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tlnef_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte expander
// Walks the queue head through its output bytes, one byte per cycle while
// the output stage can move, into a registered output stage.
// ----------------------------------------------------------------------------
module tlnef_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire tlnef_pkg::entry_t  head,
	output logic                    pop,
	tlnef_out_if.source             fmt
);

	typedef enum logic [2:0] {
		PH_NUM,
		PH_TAB,
		PH_DOLLAR,
		PH_CARET,
		PH_CHAR
	} phase_t;

	phase_t                      phase_q;
	logic                        started_q;
	logic [tlnef_pkg::COL_W-1:0] col_q;
	logic                        lead_q;
	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic                        out_run_end_q;

	phase_t                      eff_phase;
	phase_t                      next_phase;
	phase_t                      tail_phase;
	logic [tlnef_pkg::COL_W-1:0] eff_col;
	logic [tlnef_pkg::COL_W-1:0] next_col;
	logic                        eff_lead;
	logic                        lead_now;
	logic [3:0]                  digit;
	logic [7:0]                  emit_byte;
	logic                        advance;
	logic                        emit;
	logic                        last;

	assign fmt.valid    = out_valid_q;
	assign fmt.out_byte = out_byte_q;
	assign fmt.run_end  = out_run_end_q;

	// The output stage moves when it is empty or being taken.
	assign advance = !out_valid_q || fmt.ready;
	assign emit    = head_valid && advance;
	assign last    = (eff_phase == PH_CHAR);
	assign pop     = emit && last;

	// Pick the byte for the current step and the step after it.
	always_comb begin
		tail_phase = head.caret_en ? PH_CARET : PH_CHAR;
		if (started_q) begin
			eff_phase = phase_q;
		end else if (head.num_en) begin
			eff_phase = PH_NUM;
		end else if (head.dollar_en) begin
			eff_phase = PH_DOLLAR;
		end else begin
			eff_phase = tail_phase;
		end
		eff_col  = started_q ? col_q : tlnef_pkg::COL_W'(tlnef_pkg::NUMBER_DIGITS - 1);
		eff_lead = started_q ? lead_q : 1'b1;
		digit    = tlnef_pkg::digit_at(head.bcd, eff_col);
		lead_now = eff_lead && (digit == 4'd0) && (eff_col != '0);
		next_col = eff_col;
		case (eff_phase)
			PH_NUM: begin
				emit_byte = lead_now ? tlnef_pkg::CH_SPACE : (tlnef_pkg::CH_ZERO | {4'h0, digit});
				next_col  = eff_col - 1'b1;
				if (eff_col == '0) begin
					next_phase = PH_TAB;
				end else begin
					next_phase = PH_NUM;
				end
			end
			PH_TAB: begin
				emit_byte  = tlnef_pkg::CH_TAB;
				next_phase = head.dollar_en ? PH_DOLLAR : tail_phase;
			end
			PH_DOLLAR: begin
				emit_byte  = tlnef_pkg::CH_DOLLAR;
				next_phase = tail_phase;
			end
			PH_CARET: begin
				emit_byte  = tlnef_pkg::CH_CARET;
				next_phase = PH_CHAR;
			end
			PH_CHAR: begin
				emit_byte  = head.ch;
				next_phase = PH_CHAR;
			end
			default: begin
				emit_byte  = head.ch;
				next_phase = PH_CHAR;
			end
		endcase
	end

	// Step state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_CHAR;
			started_q     <= 1'b0;
			col_q         <= '0;
			lead_q        <= 1'b1;
			out_valid_q   <= 1'b0;
			out_byte_q    <= '0;
			out_run_end_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= head_valid;
				if (head_valid) begin
					out_byte_q    <= emit_byte;
					out_run_end_q <= last;
				end
			end
			if (emit) begin
				if (last) begin
					started_q <= 1'b0;
				end else begin
					started_q <= 1'b1;
					phase_q   <= next_phase;
					col_q     <= next_col;
					lead_q    <= lead_now;
				end
			end
		end
	end

`ifndef SYNTHESIS
	// An entry is only retired while one is present.
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("expander retired an entry from an empty queue");

	// A partly expanded entry stays at the queue head.
	a_started_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> head_valid)
		else $error("expansion in progress without a queue entry");

	// Retiring an entry puts its final byte, marked as run end, on the output.
	a_pop_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && out_run_end_q))
		else $error("retired entry did not produce a run end byte");
`endif

endmodule
`default_nettype wire

### hw/rtl/text_line_number_escape_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text line number and escape filter
// Reformats a text byte stream with line numbers, squeezed blank lines and
// visible line ends, tabs and control characters.
// ----------------------------------------------------------------------------
// Each raw byte yields one to NUMBER_DIGITS + 3 output bytes (none for a
// squeezed blank line), and the last byte of each group carries run_end.
// The output side moves one byte per cycle unless fmt.ready holds it, so
// an expanded byte holds the expander; plain bytes flow at one per cycle.
// A four-entry queue separates the classifier from the expander, so raw
// bytes are taken every cycle until that queue is full. Registers are
// written through the configuration channel, which is always ready; write
// them only while the filter is idle.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tlnef_in_if.sink     raw,
	tlnef_out_if.source  fmt,
	tlnef_cfg_if.sink    cfg
);

	tlnef_pkg::cfg_t   cfg_q;
	tlnef_pkg::entry_t push_entry;
	tlnef_pkg::entry_t head;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              head_valid;

	// Configuration registers; indexes beyond the list are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				tlnef_pkg::REG_NUMBER_ALL:      cfg_q.number_all_lines      <= cfg.wdata;
				tlnef_pkg::REG_NUMBER_NONBLANK: cfg_q.number_nonblank_lines <= cfg.wdata;
				tlnef_pkg::REG_SQUEEZE_BLANK:   cfg_q.squeeze_blank_lines   <= cfg.wdata;
				tlnef_pkg::REG_SHOW_ENDS:       cfg_q.show_line_ends        <= cfg.wdata;
				tlnef_pkg::REG_SHOW_TABS:       cfg_q.show_tab_chars        <= cfg.wdata;
				tlnef_pkg::REG_SHOW_CONTROL:    cfg_q.show_control_chars    <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	// Classifier.
	tlnef_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.raw    (raw),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	// Queue between classifier and expander.
	tlnef_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Expander.
	tlnef_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.fmt        (fmt)
	);

endmodule
`default_nettype wire
